>>> hw/rtl/gdr_pkg.sv
// Package for the grid DDA ray caster: constants, codes and shared types.
// Used by gdr_div and grid_dda_raycaster_top; depends on nothing.
package gdr_pkg;
  localparam int MAP_W_DEF     = 32;
  localparam int MAP_H_DEF     = 16;
  localparam int MAX_STEPS_DEF = 96;
  localparam logic [3:0]  OUT_CODE = 4'd2;
  localparam logic [17:0] MIN_DIST = 18'd41;
  localparam logic [17:0] MAX_DIST = 18'd262143;

  localparam logic [1:0] REG_PLAYER_X = 2'd0;
  localparam logic [1:0] REG_PLAYER_Y = 2'd1;
  localparam logic [1:0] REG_DARK     = 2'd2;
  localparam logic [1:0] REG_VIEW_H   = 2'd3;

  // Request to the shared divider and its answer.
  typedef struct packed {
    logic        start;
    logic [47:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [47:0] quot;
  } div_rsp_t;
endpackage

>>> hw/rtl/gdr_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// Depends on nothing.
module gdr_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/gdr_div.sv
// Restoring divider, one quotient bit per cycle, 48-bit dividend.
// Depends on gdr_pkg.
module gdr_div (
  input  logic              clk,
  input  logic              rst_n,
  input  gdr_pkg::div_req_t req,
  output gdr_pkg::div_rsp_t rsp
);
  import gdr_pkg::*;

  logic [47:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] den_r, den_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r[31:0], q_r[47]};
    if (req.start) begin
      q_nxt = req.num;
      rem_nxt = '0;
      den_nxt = req.den;
      cnt_nxt = 6'd47;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt = {q_r[46:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[46:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
endmodule

>>> hw/rtl/grid_dda_raycaster_top.sv
// Top level of the grid DDA ray caster: sequencer, DDA walk and result stage.
// Depends on gdr_pkg, gdr_ram and gdr_div.
//
// Usage. An item is transferred in when start is high and busy is low.
// A map write item (in_req_type = 1) stores in_cell_code at (in_cell_x, in_cell_y)
// when that cell lies inside the map, and gives one acknowledge result with every
// other field zero by way of the states S_WACK and S_OUT. A cast item walks the
// map from the player position by DDA, each grid step passing through compare
// and add, map read and hit test, for up to MAX_STEPS steps. The two step
// deltas and the strip height share one 48-bit bit-serial divider, so the cast
// waits for each of the three divisions in turn. Busy drops in the result cycle,
// so the next transfer can take place at the edge that ends it. Each result
// is shown for one cycle with out_valid high; the receiver cannot stall, so
// nothing is held back. Configuration writes go through cfg_we, cfg_index and
// cfg_data and are expected only while busy is low. Reset clears the sequencer
// and puts the registers at their reset values; the map is undefined until
// written.
module grid_dda_raycaster_top #(
  parameter int MAP_W     = gdr_pkg::MAP_W_DEF,
  parameter int MAP_H     = gdr_pkg::MAP_H_DEF,
  parameter int MAX_STEPS = gdr_pkg::MAX_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [8:0]  in_column,
  input  logic signed [15:0] in_dir_x,
  input  logic signed [15:0] in_dir_y,
  input  logic [14:0] in_fisheye_cos,
  input  logic [4:0]  in_cell_x,
  input  logic [3:0]  in_cell_y,
  input  logic [3:0]  in_cell_code,
  output logic        out_valid,
  output logic        out_is_write_ack,
  output logic [8:0]  out_column_out,
  output logic [17:0] out_perp_distance,
  output logic [9:0]  out_strip_top,
  output logic [9:0]  out_strip_bottom,
  output logic [3:0]  out_hit_code,
  output logic        out_hit_side,
  output logic        out_dark,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [17:0] cfg_data
);
  import gdr_pkg::*;

  localparam int XW = $clog2(MAP_W);
  localparam int YW = $clog2(MAP_H);
  localparam int AW = $clog2(MAP_W * MAP_H);
  localparam int SW = $clog2(MAX_STEPS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_WACK, S_DX, S_DXW, S_DY, S_DYW, S_SETUP,
    S_CMP, S_RD, S_HIT, S_DIST, S_MUL, S_HDIV, S_HDW, S_OUT
  } state_t;

  state_t state_r;
  logic [16:0] px_r;
  logic [15:0] py_r;
  logic [17:0] dark_r;
  logic [9:0]  vh_r;

  logic [8:0]  col_r;
  logic signed [15:0] dx_r, dy_r;
  logic [14:0] cos_r;
  logic [31:0] dlx_r, dly_r;     // Q.16 deltas
  logic        infx_r, infy_r;
  logic [63:0] sx_r, sy_r;       // side distances
  logic [63:0] stx_r, sty_r;
  logic signed [12:0] mx_r, my_r;
  logic        side_r, wr_r;
  logic [SW-1:0] steps_r;
  logic [3:0]  code_r, oob_code_r;
  logic        oob_r;
  logic [63:0] dist_r;
  logic [17:0] perp_r;
  logic        over_r, dinf_r;

  div_req_t dreq;
  div_rsp_t drsp;
  gdr_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [3:0] ram_rdata;
  logic ram_we;
  gdr_ram #(.WIDTH(4), .DEPTH(2 ** AW)) u_map (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(in_cell_code),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  logic accept;
  assign accept = start && (state_r == S_IDLE);
  assign busy = (state_r != S_IDLE);

  logic wr_ok;
  assign wr_ok = (32'(in_cell_x) < MAP_W) && (32'(in_cell_y) < MAP_H);
  assign ram_we = accept && in_req_type && wr_ok;
  assign ram_waddr = AW'(32'(in_cell_y) * MAP_W + 32'(in_cell_x));
  assign ram_raddr = AW'(32'(my_r[YW-1:0]) * MAP_W + 32'(mx_r[XW-1:0]));

  logic [15:0] magx, magy;
  assign magx = dx_r[15] ? 16'(-dx_r) : 16'(dx_r);
  assign magy = dy_r[15] ? 16'(-dy_r) : 16'(dy_r);

  logic [12:0] fx, fy, tx, ty;
  assign fx = {1'b0, px_r[11:0]};
  assign fy = {1'b0, py_r[11:0]};
  assign tx = dx_r[15] ? fx : 13'd4096 - fx;
  assign ty = dy_r[15] ? fy : 13'd4096 - fy;

  logic xless;
  assign xless = (infx_r != infy_r) ? !infx_r : (sx_r < sy_r);

  logic [63:0] dlast;
  logic        inflast;
  assign dlast = side_r ? sy_r - sty_r : sx_r - stx_r;
  assign inflast = side_r ? infy_r : infx_r;

  // A finite distance stays below 2^51 even at 256 steps, so bits 50:12 hold it whole.
  logic [53:0] prod;
  assign prod = 54'(dist_r[50:12]) * 54'(cos_r);

  logic [47:0] hq;
  logic signed [11:0] hor, topv, botv;
  assign hq = drsp.quot;
  assign hor = 12'(vh_r >> 1);

  always_comb begin
    dreq = '0;
    case (state_r)
      S_DX: begin
        dreq.start = 1'b1;
        dreq.num = 48'h4000_0000;
        dreq.den = 32'(magx);
      end
      S_DY: begin
        dreq.start = 1'b1;
        dreq.num = 48'h4000_0000;
        dreq.den = 32'(magy);
      end
      S_HDIV: begin
        dreq.start = 1'b1;
        dreq.num = 48'(vh_r) << 12;
        dreq.den = 32'(perp_r);
      end
      default: dreq = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      px_r <= 17'd10240;
      py_r <= 16'd10240;
      dark_r <= 18'd20480;
      vh_r <= 10'd206;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_PLAYER_X: px_r <= cfg_data[16:0];
          REG_PLAYER_Y: py_r <= cfg_data[15:0];
          REG_DARK:     dark_r <= cfg_data;
          REG_VIEW_H:   vh_r <= cfg_data[9:0];
          default:      vh_r <= vh_r;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            col_r <= in_column;
            dx_r <= in_dir_x;
            dy_r <= in_dir_y;
            cos_r <= in_fisheye_cos;
            wr_r <= in_req_type;
            state_r <= in_req_type ? S_WACK : S_DX;
          end
        end
        S_WACK: state_r <= S_OUT;
        S_DX: state_r <= S_DXW;
        S_DXW: if (drsp.done) begin
          dlx_r <= drsp.quot[31:0];
          state_r <= S_DY;
        end
        S_DY: state_r <= S_DYW;
        S_DYW: if (drsp.done) begin
          dly_r <= drsp.quot[31:0];
          state_r <= S_SETUP;
        end
        S_SETUP: begin
          infx_r <= (dx_r == 16'sd0);
          infy_r <= (dy_r == 16'sd0);
          sx_r <= (dx_r == 16'sd0) ? 64'(tx) : 64'(tx) * 64'(dlx_r);
          sy_r <= (dy_r == 16'sd0) ? 64'(ty) : 64'(ty) * 64'(dly_r);
          stx_r <= (dx_r == 16'sd0) ? 64'd4096 : 64'(dlx_r) << 12;
          sty_r <= (dy_r == 16'sd0) ? 64'd4096 : 64'(dly_r) << 12;
          mx_r <= 13'(px_r >> 12);
          my_r <= 13'(py_r >> 12);
          steps_r <= '0;
          side_r <= 1'b0;
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (xless) begin
            sx_r <= sx_r + stx_r;
            mx_r <= dx_r[15] ? mx_r - 13'sd1 : mx_r + 13'sd1;
            side_r <= 1'b0;
          end else begin
            sy_r <= sy_r + sty_r;
            my_r <= dy_r[15] ? my_r - 13'sd1 : my_r + 13'sd1;
            side_r <= 1'b1;
          end
          steps_r <= steps_r + SW'(1);
          state_r <= S_RD;
        end
        S_RD: begin
          oob_r <= mx_r < 0 || my_r < 0 || 32'(mx_r) >= MAP_W || 32'(my_r) >= MAP_H;
          oob_code_r <= OUT_CODE;
          state_r <= S_HIT;
        end
        S_HIT: begin
          code_r <= oob_r ? oob_code_r : ram_rdata;
          if ((oob_r ? oob_code_r : ram_rdata) != 4'd0 || 32'(steps_r) >= MAX_STEPS) begin
            state_r <= S_DIST;
          end else begin
            state_r <= S_CMP;
          end
        end
        S_DIST: begin
          dist_r <= dlast;
          dinf_r <= inflast && dlast != 64'd0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          if (dinf_r) begin
            over_r <= cos_r != 15'd0;
            perp_r <= (cos_r == 15'd0) ? MIN_DIST : MAX_DIST;
          end else if ((prod >> 18) > 54'(MAX_DIST)) begin
            over_r <= 1'b1;
            perp_r <= MAX_DIST;
          end else begin
            over_r <= 1'b0;
            perp_r <= (18'(prod >> 18) < MIN_DIST) ? MIN_DIST : 18'(prod >> 18);
          end
          state_r <= S_HDIV;
        end
        S_HDIV: state_r <= S_HDW;
        S_HDW: if (drsp.done) state_r <= S_OUT;
        S_OUT: begin
          out_valid <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Strip rows from the height quotient; h is at most view_height*4096/41.
  logic [16:0] hh;
  assign hh = 17'(hq >> 1);
  assign topv = (17'(hor) < hh) ? 12'sd0 : 12'(17'(hor) - hh);
  assign botv = (17'(hor) + hh > 17'(vh_r) - 17'd1 || vh_r == 10'd0) ?
                ((vh_r == 10'd0) ? 12'sd0 : 12'(vh_r - 10'd1)) : 12'(17'(hor) + hh);

  always_ff @(posedge clk) begin
    if (state_r == S_OUT) begin
      out_is_write_ack <= wr_r;
      out_column_out <= wr_r ? 9'd0 : col_r;
      out_perp_distance <= wr_r ? 18'd0 : perp_r;
      out_strip_top <= wr_r ? 10'd0 : 10'(topv);
      out_strip_bottom <= wr_r ? 10'd0 : 10'(botv);
      out_hit_code <= wr_r ? 4'd0 : code_r;
      out_hit_side <= wr_r ? 1'b0 : side_r;
      out_dark <= wr_r ? 1'b0 : (side_r || over_r || perp_r > dark_r);
    end
  end
endmodule
